@@ src/tlfip_pkg.sv @@
// package for the two-level free index pool
// holds the controller state type and the request and status codes; no dependencies
package tlfip_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REFILL,
    ST_REFILL_WR,
    ST_POP,
    ST_POP_DATA,
    ST_SPILL,
    ST_SPILL_WR,
    ST_PUSH,
    ST_FINISH
  } state_t;

  typedef logic [1:0] status_t;

  localparam logic    REQ_ALLOC       = 1'b0;
  localparam logic    REQ_RELEASE     = 1'b1;

  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_EMPTY    = 2'd1;
  localparam status_t STATUS_NO_ROOM  = 2'd2;
  localparam status_t STATUS_BAD_IDX  = 2'd3;

endpackage

@@ src/two_level_free_index_pool.sv @@
// two-level free index pool: shared ring plus local cache of free indices in sync memories
// depends on tlfip_pkg; an allocate hit steps through ST_POP, ST_POP_DATA and ST_FINISH,
// a release hit through ST_PUSH and ST_FINISH, a bad index straight to ST_FINISH; a new
// input beat is taken only back in ST_IDLE; an empty cache is refilled before an allocate
// and a full cache spilled before a release, each move a memory read then a write
// reset: synchronous; no clearing pass, unwritten shared ring entries read as their address
module two_level_free_index_pool #(
  parameter int POOL_ENTRIES  = 1024,
  parameter int LOCAL_ENTRIES = 64,
  localparam int IDX_W = $clog2(POOL_ENTRIES),
  localparam int CNT_W = $clog2(POOL_ENTRIES + 1),
  localparam int IN_W  = ((IDX_W + 7) / 8) * 8,
  localparam int OUT_W = ((IDX_W + 2 * CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // release_index
  input  logic             in_tuser,   // req_type
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // alloc_index, free_count, low_water
  output logic [1:0]       out_tuser   // status
);

  localparam int LPTR_W = $clog2(LOCAL_ENTRIES);
  localparam int LCNT_W = $clog2(LOCAL_ENTRIES + 1);
  localparam int HALF   = LOCAL_ENTRIES / 2;
  localparam int MV_W   = $clog2(HALF + 1);
  localparam int SUM_W  = (CNT_W > LCNT_W ? CNT_W : LCNT_W) + 1;

  localparam logic [IDX_W-1:0]  SH_LAST  = IDX_W'(POOL_ENTRIES - 1);
  localparam logic [CNT_W-1:0]  SH_FULL  = CNT_W'(POOL_ENTRIES);
  localparam logic [LPTR_W-1:0] LC_LAST  = LPTR_W'(LOCAL_ENTRIES - 1);
  localparam logic [LCNT_W-1:0] LC_FULL  = LCNT_W'(LOCAL_ENTRIES);
  localparam logic [MV_W-1:0]   MV_LAST  = MV_W'(HALF);

  logic [IDX_W-1:0] shared_mem [POOL_ENTRIES];
  logic [IDX_W-1:0] local_mem  [LOCAL_ENTRIES];

  tlfip_pkg::state_t  state_r, state_nxt;
  logic               req_r, req_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   sh_wr_ptr_r, sh_wr_ptr_nxt;
  logic [IDX_W-1:0]   sh_rd_ptr_r, sh_rd_ptr_nxt;
  logic [CNT_W-1:0]   sh_count_r, sh_count_nxt;
  logic               sh_wrapped_r, sh_wrapped_nxt;
  logic [LPTR_W-1:0]  lc_wr_ptr_r, lc_wr_ptr_nxt;
  logic [LPTR_W-1:0]  lc_rd_ptr_r, lc_rd_ptr_nxt;
  logic [LCNT_W-1:0]  lc_count_r, lc_count_nxt;
  logic [CNT_W-1:0]   low_mark_r, low_mark_nxt;
  logic [MV_W-1:0]    move_cnt_r, move_cnt_nxt;
  tlfip_pkg::status_t status_r, status_nxt;
  logic [IDX_W-1:0]   alloc_r, alloc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]   out_alloc_r, out_alloc_nxt;
  tlfip_pkg::status_t out_status_r, out_status_nxt;
  logic [CNT_W-1:0]   out_free_r, out_free_nxt;
  logic [CNT_W-1:0]   out_low_r, out_low_nxt;

  logic               sh_re, sh_we, lc_re, lc_we;
  logic [IDX_W-1:0]   sh_rdata_r, lc_rdata_r, lc_wdata;
  logic               sh_fresh_r;
  logic [IDX_W-1:0]   sh_fresh_addr_r;
  logic [SUM_W-1:0]   free_sum;
  logic [IDX_W-1:0]   in_idx;

  assign in_idx    = in_tdata[IDX_W-1:0];
  assign in_tready = (state_r == tlfip_pkg::ST_IDLE);
  assign free_sum  = SUM_W'(lc_count_r) + SUM_W'(sh_count_r);
  assign lc_wdata  = (state_r == tlfip_pkg::ST_PUSH) ? idx_r :
                     (sh_fresh_r ? sh_fresh_addr_r : sh_rdata_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_low_r, out_free_r, out_alloc_r});
  assign out_tuser  = out_status_r;

  // ring memories
  always_ff @(posedge clk) begin
    if (sh_we) begin
      shared_mem[sh_wr_ptr_r] <= lc_rdata_r;
    end
    if (sh_re) begin
      sh_rdata_r      <= shared_mem[sh_rd_ptr_r];
      sh_fresh_r      <= !sh_wrapped_r && (sh_rd_ptr_r >= sh_wr_ptr_r);
      sh_fresh_addr_r <= sh_rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (lc_we) begin
      local_mem[lc_wr_ptr_r] <= lc_wdata;
    end
    if (lc_re) begin
      lc_rdata_r <= local_mem[lc_rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tlfip_pkg::ST_IDLE;
      sh_wr_ptr_r  <= '0;
      sh_rd_ptr_r  <= '0;
      sh_count_r   <= SH_FULL;
      sh_wrapped_r <= 1'b0;
      lc_wr_ptr_r  <= '0;
      lc_rd_ptr_r  <= '0;
      lc_count_r   <= '0;
      low_mark_r   <= SH_FULL;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sh_wr_ptr_r  <= sh_wr_ptr_nxt;
      sh_rd_ptr_r  <= sh_rd_ptr_nxt;
      sh_count_r   <= sh_count_nxt;
      sh_wrapped_r <= sh_wrapped_nxt;
      lc_wr_ptr_r  <= lc_wr_ptr_nxt;
      lc_rd_ptr_r  <= lc_rd_ptr_nxt;
      lc_count_r   <= lc_count_nxt;
      low_mark_r   <= low_mark_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    move_cnt_r   <= move_cnt_nxt;
    status_r     <= status_nxt;
    alloc_r      <= alloc_nxt;
    out_alloc_r  <= out_alloc_nxt;
    out_status_r <= out_status_nxt;
    out_free_r   <= out_free_nxt;
    out_low_r    <= out_low_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    sh_wr_ptr_nxt  = sh_wr_ptr_r;
    sh_rd_ptr_nxt  = sh_rd_ptr_r;
    sh_count_nxt   = sh_count_r;
    sh_wrapped_nxt = sh_wrapped_r;
    lc_wr_ptr_nxt  = lc_wr_ptr_r;
    lc_rd_ptr_nxt  = lc_rd_ptr_r;
    lc_count_nxt   = lc_count_r;
    low_mark_nxt   = low_mark_r;
    move_cnt_nxt   = move_cnt_r;
    status_nxt     = status_r;
    alloc_nxt      = alloc_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_alloc_nxt  = out_alloc_r;
    out_status_nxt = out_status_r;
    out_free_nxt   = out_free_r;
    out_low_nxt    = out_low_r;
    sh_re          = 1'b0;
    sh_we          = 1'b0;
    lc_re          = 1'b0;
    lc_we          = 1'b0;

    case (state_r)
      tlfip_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          req_nxt      = in_tuser;
          idx_nxt      = in_idx;
          status_nxt   = tlfip_pkg::STATUS_OK;
          alloc_nxt    = '0;
          move_cnt_nxt = '0;
          if (in_tuser == tlfip_pkg::REQ_ALLOC) begin
            state_nxt = (lc_count_r == '0) ? tlfip_pkg::ST_REFILL : tlfip_pkg::ST_POP;
          end else if (CNT_W'(in_idx) >= SH_FULL) begin
            status_nxt = tlfip_pkg::STATUS_BAD_IDX;
            state_nxt  = tlfip_pkg::ST_FINISH;
          end else if (lc_count_r >= LC_FULL) begin
            state_nxt = tlfip_pkg::ST_SPILL;
          end else begin
            state_nxt = tlfip_pkg::ST_PUSH;
          end
        end
      end
      // shared ring to cache, each index read in ST_REFILL and written in ST_REFILL_WR
      tlfip_pkg::ST_REFILL: begin
        if (move_cnt_r == MV_LAST || lc_count_r >= LC_FULL || sh_count_r == '0) begin
          if (sh_count_r < low_mark_r) begin
            low_mark_nxt = sh_count_r;
          end
          state_nxt = tlfip_pkg::ST_POP;
        end else begin
          sh_re         = 1'b1;
          sh_rd_ptr_nxt = (sh_rd_ptr_r == SH_LAST) ? '0 : sh_rd_ptr_r + 1'b1;
          sh_count_nxt  = sh_count_r - 1'b1;
          state_nxt     = tlfip_pkg::ST_REFILL_WR;
        end
      end
      tlfip_pkg::ST_REFILL_WR: begin
        lc_we         = 1'b1;
        lc_wr_ptr_nxt = (lc_wr_ptr_r == LC_LAST) ? '0 : lc_wr_ptr_r + 1'b1;
        lc_count_nxt  = lc_count_r + 1'b1;
        move_cnt_nxt  = move_cnt_r + 1'b1;
        state_nxt     = tlfip_pkg::ST_REFILL;
      end
      tlfip_pkg::ST_POP: begin
        if (lc_count_r == '0) begin
          status_nxt = tlfip_pkg::STATUS_EMPTY;
          state_nxt  = tlfip_pkg::ST_FINISH;
        end else begin
          lc_re         = 1'b1;
          lc_rd_ptr_nxt = (lc_rd_ptr_r == LC_LAST) ? '0 : lc_rd_ptr_r + 1'b1;
          lc_count_nxt  = lc_count_r - 1'b1;
          state_nxt     = tlfip_pkg::ST_POP_DATA;
        end
      end
      tlfip_pkg::ST_POP_DATA: begin
        alloc_nxt = lc_rdata_r;
        state_nxt = tlfip_pkg::ST_FINISH;
      end
      // cache to shared ring, oldest first
      tlfip_pkg::ST_SPILL: begin
        if (move_cnt_r == MV_LAST || sh_count_r >= SH_FULL || lc_count_r == '0) begin
          state_nxt = tlfip_pkg::ST_PUSH;
        end else begin
          lc_re         = 1'b1;
          lc_rd_ptr_nxt = (lc_rd_ptr_r == LC_LAST) ? '0 : lc_rd_ptr_r + 1'b1;
          lc_count_nxt  = lc_count_r - 1'b1;
          state_nxt     = tlfip_pkg::ST_SPILL_WR;
        end
      end
      tlfip_pkg::ST_SPILL_WR: begin
        sh_we = 1'b1;
        if (sh_wr_ptr_r == SH_LAST) begin
          sh_wr_ptr_nxt  = '0;
          sh_wrapped_nxt = 1'b1;
        end else begin
          sh_wr_ptr_nxt = sh_wr_ptr_r + 1'b1;
        end
        sh_count_nxt = sh_count_r + 1'b1;
        move_cnt_nxt = move_cnt_r + 1'b1;
        state_nxt    = tlfip_pkg::ST_SPILL;
      end
      tlfip_pkg::ST_PUSH: begin
        if (lc_count_r >= LC_FULL) begin
          status_nxt = tlfip_pkg::STATUS_NO_ROOM;
        end else begin
          lc_we         = 1'b1;
          lc_wr_ptr_nxt = (lc_wr_ptr_r == LC_LAST) ? '0 : lc_wr_ptr_r + 1'b1;
          lc_count_nxt  = lc_count_r + 1'b1;
        end
        state_nxt = tlfip_pkg::ST_FINISH;
      end
      tlfip_pkg::ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_alloc_nxt  = (req_r == tlfip_pkg::REQ_ALLOC) ? alloc_r : '0;
          out_status_nxt = status_r;
          out_free_nxt   = free_sum[CNT_W-1:0];
          out_low_nxt    = low_mark_r;
          state_nxt      = tlfip_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tlfip_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ tb/two_level_free_index_pool_checker.sv @@
// checker for the two-level free index pool: watches both stream channels,
// predicts every result beat from its own copy of both rings and compares them
// depends on tlfip_pkg for the request and status codes
module two_level_free_index_pool_checker #(
  parameter int POOL_ENTRIES  = 1024,
  parameter int LOCAL_ENTRIES = 64,
  localparam int IDX_W = $clog2(POOL_ENTRIES),
  localparam int CNT_W = $clog2(POOL_ENTRIES + 1),
  localparam int IN_W  = ((IDX_W + 7) / 8) * 8,
  localparam int OUT_W = ((IDX_W + 2 * CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // release_index
  input  logic             in_tuser,   // req_type
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,  // alloc_index, free_count, low_water
  input  logic [1:0]       out_tuser,  // status
  output int               fail_count,
  output int               pending,
  output int               result_count,
  output int               empty_count,
  output int               no_room_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0]   alloc_index;
    tlfip_pkg::status_t status;
    logic [CNT_W-1:0]   free_count;
    logic [CNT_W-1:0]   low_water;
  } pool_result_t;

  logic [IDX_W-1:0] shared_free [POOL_ENTRIES];
  logic [IDX_W-1:0] cache_free [LOCAL_ENTRIES];
  int shared_wr;
  int shared_cnt;
  int cache_wr;
  int cache_cnt;
  int shared_low;
  pool_result_t expected_results [$];

  function automatic pool_result_t serve_request(logic req, logic [IDX_W-1:0] idx);
    pool_result_t r;
    int n;
    r = '0;
    if (req == tlfip_pkg::REQ_ALLOC) begin
      if (cache_cnt == 0) begin
        for (n = 0; n < LOCAL_ENTRIES / 2 && shared_cnt > 0; n++) begin
          cache_free[cache_wr] =
            shared_free[(shared_wr + POOL_ENTRIES - shared_cnt) % POOL_ENTRIES];
          cache_wr = (cache_wr + 1) % LOCAL_ENTRIES;
          cache_cnt++;
          shared_cnt--;
        end
        if (shared_cnt < shared_low) shared_low = shared_cnt;
      end
      if (cache_cnt > 0) begin
        r.alloc_index = cache_free[(cache_wr + LOCAL_ENTRIES - cache_cnt) % LOCAL_ENTRIES];
        cache_cnt--;
      end else begin
        r.status = tlfip_pkg::STATUS_EMPTY;
      end
    end else if (idx >= POOL_ENTRIES) begin
      r.status = tlfip_pkg::STATUS_BAD_IDX;
    end else begin
      if (cache_cnt >= LOCAL_ENTRIES) begin
        for (n = 0; n < LOCAL_ENTRIES / 2 && shared_cnt < POOL_ENTRIES; n++) begin
          shared_free[shared_wr] =
            cache_free[(cache_wr + LOCAL_ENTRIES - cache_cnt) % LOCAL_ENTRIES];
          shared_wr = (shared_wr + 1) % POOL_ENTRIES;
          shared_cnt++;
          cache_cnt--;
        end
      end
      if (cache_cnt < LOCAL_ENTRIES) begin
        cache_free[cache_wr] = idx;
        cache_wr = (cache_wr + 1) % LOCAL_ENTRIES;
        cache_cnt++;
      end else begin
        r.status = tlfip_pkg::STATUS_NO_ROOM;
      end
    end
    r.free_count = CNT_W'(cache_cnt + shared_cnt);
    r.low_water  = CNT_W'(shared_low);
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    pool_result_t exp_r;
    logic [IDX_W-1:0] got_alloc;
    logic [CNT_W-1:0] got_free;
    logic [CNT_W-1:0] got_low;
    int errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < POOL_ENTRIES; i++) shared_free[i] = IDX_W'(i);
      for (int i = 0; i < LOCAL_ENTRIES; i++) cache_free[i] = '0;
      shared_wr  = 0;
      shared_cnt = POOL_ENTRIES;
      cache_wr   = 0;
      cache_cnt  = 0;
      shared_low = POOL_ENTRIES;
      expected_results.delete();
      fail_count    <= 0;
      result_count  <= 0;
      empty_count   <= 0;
      no_room_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(serve_request(in_tuser, in_tdata[IDX_W-1:0]));
      if (out_tvalid && out_tready) begin
        got_alloc = out_tdata[IDX_W-1:0];
        got_free  = out_tdata[IDX_W +: CNT_W];
        got_low   = out_tdata[IDX_W + CNT_W +: CNT_W];
        result_count <= result_count + 1;
        if (out_tuser == tlfip_pkg::STATUS_EMPTY) empty_count <= empty_count + 1;
        if (out_tuser == tlfip_pkg::STATUS_NO_ROOM) no_room_count <= no_room_count + 1;
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: alloc_index %0d status %0d",
                 got_alloc, out_tuser);
          errs++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got_alloc !== exp_r.alloc_index) begin
            $error("alloc_index mismatch: expected %0d, got %0d", exp_r.alloc_index, got_alloc);
            errs++;
          end
          if (out_tuser !== exp_r.status) begin
            $error("status mismatch: expected %0d, got %0d", exp_r.status, out_tuser);
            errs++;
          end
          if (got_free !== exp_r.free_count) begin
            $error("free_count mismatch: expected %0d, got %0d", exp_r.free_count, got_free);
            errs++;
          end
          if (got_low !== exp_r.low_water) begin
            $error("low_water mismatch: expected %0d, got %0d", exp_r.low_water, got_low);
            errs++;
          end
        end
        if (errs > 0) fail_count <= fail_count + errs;
      end
    end
  end

endmodule

@@ tb/tb.sv @@
// testbench top for the two-level free index pool: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict; checking is done by the checker module
// depends on tlfip_pkg, two_level_free_index_pool and two_level_free_index_pool_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_ENTRIES  = 1024;
  localparam int LOCAL_ENTRIES = 64;
  localparam int IDX_W = $clog2(POOL_ENTRIES);
  localparam int CNT_W = $clog2(POOL_ENTRIES + 1);
  localparam int IN_W  = ((IDX_W + 7) / 8) * 8;
  localparam int OUT_W = ((IDX_W + 2 * CNT_W + 7) / 8) * 8;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 400;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;   // release_index
  logic             in_tuser;   // req_type
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // alloc_index, free_count, low_water
  logic [1:0]       out_tuser;  // status

  int fail_count;
  int pending;
  int result_count;
  int empty_count;
  int no_room_count;
  int idle_cycles;
  int free_estimate;
  int requests_sent;
  bit no_gaps;

  two_level_free_index_pool #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .LOCAL_ENTRIES(LOCAL_ENTRIES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  two_level_free_index_pool_checker #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .LOCAL_ENTRIES(LOCAL_ENTRIES)
  ) u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .empty_count  (empty_count),
    .no_room_count(no_room_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input logic req, input logic [IDX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= IN_W'(idx);
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    if (req == tlfip_pkg::REQ_ALLOC) begin
      if (free_estimate > 0) free_estimate--;
    end else if (free_estimate < POOL_ENTRIES + LOCAL_ENTRIES) begin
      free_estimate++;
    end
  endtask

  task automatic send_random(input int alloc_pct);
    logic [IDX_W-1:0] idx;
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) idx = '0;
    else if (r < 10) idx = IDX_W'(POOL_ENTRIES - 1);
    else idx = IDX_W'($urandom_range(0, POOL_ENTRIES - 1));
    if ($urandom_range(0, 99) < alloc_pct) send_request(tlfip_pkg::REQ_ALLOC, IDX_W'($urandom));
    else send_request(tlfip_pkg::REQ_RELEASE, idx);
    if ((requests_sent % 64) == 0) no_gaps = ($urandom_range(0, 3) == 0);
  endtask

  // result side back-pressure, with one long hold-off while requests keep coming
  initial begin
    int cyc;
    int mode;
    int stretch;
    bit held;
    cyc = 0;
    held = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && cyc > 3000) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      mode = $urandom_range(0, 9);
      stretch = $urandom_range(20, 200);
      repeat (stretch) begin
        if (mode < 3) out_tready <= 1'b1;
        else if (mode < 8) out_tready <= ($urandom_range(0, 99) < 70);
        else out_tready <= ($urandom_range(0, 99) < 15);
        @(posedge clk);
        cyc++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results pending", idle_cycles, pending);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int extra;
    idle_cycles   = 0;
    free_estimate = POOL_ENTRIES;
    requests_sent = 0;
    no_gaps       = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= tlfip_pkg::REQ_ALLOC;
    in_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first allocates refill the empty cache, then boundary release indices
    send_request(tlfip_pkg::REQ_ALLOC, '0);
    send_request(tlfip_pkg::REQ_ALLOC, '1);
    send_request(tlfip_pkg::REQ_ALLOC, '0);
    send_request(tlfip_pkg::REQ_RELEASE, '0);
    send_request(tlfip_pkg::REQ_RELEASE, IDX_W'(POOL_ENTRIES - 1));
    send_request(tlfip_pkg::REQ_RELEASE, IDX_W'(10'h2AA));
    send_request(tlfip_pkg::REQ_RELEASE, IDX_W'(10'h155));
    send_request(tlfip_pkg::REQ_ALLOC, '0);
    send_request(tlfip_pkg::REQ_RELEASE, IDX_W'(1));
    send_request(tlfip_pkg::REQ_RELEASE, IDX_W'(1));
    send_request(tlfip_pkg::REQ_ALLOC, '0);
    send_request(tlfip_pkg::REQ_ALLOC, '0);

    // release-heavy: shared ring fills, spills stop at full, no room on release
    repeat (110) send_random(5);
    // allocate-heavy: drain through the shared ring until the pool runs dry
    extra = 0;
    while ((free_estimate > 0 || extra < 40) && requests_sent < 1400) begin
      send_random(97);
      if (free_estimate == 0) extra++;
    end
    // mixed traffic around an almost empty pool, then a balanced mix
    repeat (60) send_random(40);
    repeat (120) send_random(50);
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("requests: %0d, results checked: %0d", requests_sent, result_count);
    $display("pool empty results: %0d, no room results: %0d", empty_count, no_room_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
